// ----- rtl/core/lvm_pkg.sv -----
// Package for the look-at view matrix block: beat types, register indexes,
// widths and the fixed-point helper functions.
// No dependencies.
package lvm_pkg;

    // Default number of fraction bits (Q16.16)
    localparam int LVM_FRAC_BITS = 16;

    // Width of the vectors fed to the normalizer (difference of two 32-bit values,
    // or a cross product of truncated products)
    localparam int NW = 34;

    // Configuration port
    localparam int CFG_IW = 2;
    localparam logic [CFG_IW-1:0] REG_UP_X = 2'd0;
    localparam logic [CFG_IW-1:0] REG_UP_Y = 2'd1;
    localparam logic [CFG_IW-1:0] REG_UP_Z = 2'd2;

    // Input beat
    typedef struct packed {
        logic signed [31:0] eye_x;
        logic signed [31:0] eye_y;
        logic signed [31:0] eye_z;
        logic signed [31:0] aim_x;
        logic signed [31:0] aim_y;
        logic signed [31:0] aim_z;
    } t_in;

    // Result beat
    typedef struct packed {
        logic signed [31:0] m00;
        logic signed [31:0] m01;
        logic signed [31:0] m02;
        logic signed [31:0] m10;
        logic signed [31:0] m11;
        logic signed [31:0] m12;
        logic signed [31:0] m20;
        logic signed [31:0] m21;
        logic signed [31:0] m22;
        logic signed [31:0] m03;
        logic signed [31:0] m13;
        logic signed [31:0] m23;
    } t_out;

    // Full 32x32 signed product
    function automatic logic signed [63:0] smul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return 64'(a) * 64'(b);
    endfunction

    // Drop the fraction bits of a product, rounding toward zero
    function automatic logic signed [63:0] qtr(input logic signed [63:0] p,
                                               input int f);
        logic signed [63:0] bias;
        bias = (64'sd1 <<< f) - 64'sd1;
        if (p[63]) begin
            return (p + bias) >>> f;
        end
        return p >>> f;
    endfunction

    // Clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

// ----- rtl/core/lvm_norm.sv -----
// Pipelined 3-vector normalizer: magnitude scaling, square root and three
// restoring dividers, with a sideband word that travels alongside.
// Depends on lvm_pkg.
module lvm_norm
    import lvm_pkg::*;
#(
    parameter int FRAC_BITS = LVM_FRAC_BITS,
    parameter int SB_W      = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [2:0][NW-1:0]    i_vec,
    input  logic [SB_W-1:0]       i_sb,
    output logic                  o_valid,
    output logic [2:0][31:0]      o_vec,
    output logic [SB_W-1:0]       o_sb
);

    localparam int QW      = FRAC_BITS + 1;       // quotient bits, value <= 1.0
    localparam int SQ_ITER = 32;                  // result bits of a 64-bit root
    localparam int SQ_ST   = SQ_ITER / 2;         // two root bits per stage
    localparam int DIV_ST  = (QW + 1) / 2;        // two quotient bits per stage
    localparam int LAT     = 6 + SQ_ST + DIV_ST;
    localparam int PW      = $clog2(NW);
    localparam int TOP     = 30;                  // scaled max lands in [2^30, 2^31)
    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

    typedef struct packed {
        logic [2:0][30:0] sm;
        logic [2:0]       neg;
        logic             zero;
        logic [SB_W-1:0]  sb;
    } t_carry;

    typedef struct packed {
        logic [63:0] n;
        logic [63:0] res;
    } t_sqrt;

    typedef struct packed {
        logic [2:0][32:0]   rem;
        logic [2:0][QW-1:0] q;
        logic [31:0]        len;
        logic [2:0]         neg;
        logic               zero;
        logic [SB_W-1:0]    sb;
    } t_div;

    // One digit of the bitwise integer square root
    function automatic t_sqrt sq_step(input t_sqrt s, input int k);
        logic [63:0] bt;
        logic [63:0] trial;
        t_sqrt r;
        bt    = 64'd1 << (62 - 2 * k);
        trial = s.res + bt;
        r     = s;
        if (s.n >= trial) begin
            r.n   = s.n - trial;
            r.res = (s.res >> 1) + bt;
        end else begin
            r.res = s.res >> 1;
        end
        return r;
    endfunction

    // One quotient bit of the three dividers; step 0 compares without a shift
    function automatic t_div dv_step(input t_div d, input int t);
        logic [32:0] x;
        t_div r;
        r = d;
        if (t <= FRAC_BITS) begin
            for (int i = 0; i < 3; i++) begin
                x = (t == 0) ? d.rem[i] : {d.rem[i][31:0], 1'b0};
                if (x >= {1'b0, d.len}) begin
                    r.rem[i] = x - {1'b0, d.len};
                    r.q[i]   = {d.q[i][QW-2:0], 1'b1};
                end else begin
                    r.rem[i] = x;
                    r.q[i]   = {d.q[i][QW-2:0], 1'b0};
                end
            end
        end
        return r;
    endfunction

    logic [LAT-1:0]          r_vld;
    logic [2:0][NW-1:0]      r_a_mag;
    logic [2:0]              r_a_neg;
    logic [SB_W-1:0]         r_a_sb;
    logic [2:0][NW-1:0]      r_b_mag;
    logic [2:0]              r_b_neg;
    logic                    r_b_zero;
    logic [PW-1:0]           r_b_pos;
    logic [SB_W-1:0]         r_b_sb;
    t_carry                  r_c;
    t_carry                  r_d;
    logic [2:0][61:0]        r_d_sq;
    t_carry                  r_e;
    logic [63:0]             r_e_sum;
    t_sqrt                   r_sq  [SQ_ST];
    t_carry                  r_sqc [SQ_ST];
    t_div                    r_dv  [DIV_ST];
    logic [2:0][31:0]        r_o_vec;
    logic [SB_W-1:0]         r_o_sb;

    logic [2:0][NW-1:0]      n_a_mag;
    logic [2:0]              n_a_neg;
    logic [NW-1:0]           n_b_max;
    logic                    n_b_zero;
    logic [PW-1:0]           n_b_pos;
    t_carry                  n_c;
    t_sqrt                   n_sq0;
    t_div                    n_dv0;
    logic [2:0][31:0]        n_o_vec;

    // Stage A: signs and magnitudes
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_a_neg[i] = i_vec[i][NW-1];
            n_a_mag[i] = n_a_neg[i] ? NW'(-$signed(i_vec[i])) : i_vec[i];
        end
    end

    // Stage B: largest magnitude and its leading one
    always_comb begin
        n_b_max = r_a_mag[0];
        if (r_a_mag[1] > n_b_max) begin
            n_b_max = r_a_mag[1];
        end
        if (r_a_mag[2] > n_b_max) begin
            n_b_max = r_a_mag[2];
        end
        n_b_zero = (n_b_max == '0);
        n_b_pos  = '0;
        for (int b = 0; b < NW; b++) begin
            if (n_b_max[b]) begin
                n_b_pos = PW'(b);
            end
        end
    end

    // Stage C: common scaling so the largest magnitude has its top bit at TOP
    always_comb begin
        n_c.neg  = r_b_neg;
        n_c.zero = r_b_zero;
        n_c.sb   = r_b_sb;
        for (int i = 0; i < 3; i++) begin
            if (r_b_pos >= PW'(TOP)) begin
                n_c.sm[i] = 31'(r_b_mag[i] >> (r_b_pos - PW'(TOP)));
            end else begin
                n_c.sm[i] = 31'(r_b_mag[i] << (PW'(TOP) - r_b_pos));
            end
        end
    end

    // Root seed and divider seed
    always_comb begin
        n_sq0.n   = r_e_sum;
        n_sq0.res = '0;
        n_dv0.len  = r_sq[SQ_ST-1].res[31:0];
        n_dv0.neg  = r_sqc[SQ_ST-1].neg;
        n_dv0.zero = r_sqc[SQ_ST-1].zero;
        n_dv0.sb   = r_sqc[SQ_ST-1].sb;
        for (int i = 0; i < 3; i++) begin
            n_dv0.rem[i] = 33'(r_sqc[SQ_ST-1].sm[i]);
            n_dv0.q[i]   = '0;
        end
    end

    // Output: restore signs, zero vector becomes the x axis
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_dv[DIV_ST-1].zero) begin
                n_o_vec[i] = (i == 0) ? ONE : '0;
            end else if (r_dv[DIV_ST-1].neg[i]) begin
                n_o_vec[i] = -(32'(r_dv[DIV_ST-1].q[i]));
            end else begin
                n_o_vec[i] = 32'(r_dv[DIV_ST-1].q[i]);
            end
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // Payload pipeline, advances every cycle
    always_ff @(posedge i_clk) begin
        r_a_mag  <= n_a_mag;
        r_a_neg  <= n_a_neg;
        r_a_sb   <= i_sb;
        r_b_mag  <= r_a_mag;
        r_b_neg  <= r_a_neg;
        r_b_zero <= n_b_zero;
        r_b_pos  <= n_b_pos;
        r_b_sb   <= r_a_sb;
        r_c      <= n_c;
        r_d      <= r_c;
        for (int i = 0; i < 3; i++) begin
            r_d_sq[i] <= 62'(r_c.sm[i]) * 62'(r_c.sm[i]);
        end
        r_e     <= r_d;
        r_e_sum <= 64'(r_d_sq[0]) + 64'(r_d_sq[1]) + 64'(r_d_sq[2]);
        r_sq[0]  <= sq_step(sq_step(n_sq0, 0), 1);
        r_sqc[0] <= r_e;
        for (int j = 1; j < SQ_ST; j++) begin
            r_sq[j]  <= sq_step(sq_step(r_sq[j-1], 2 * j), 2 * j + 1);
            r_sqc[j] <= r_sqc[j-1];
        end
        r_dv[0] <= dv_step(dv_step(n_dv0, 0), 1);
        for (int j = 1; j < DIV_ST; j++) begin
            r_dv[j] <= dv_step(dv_step(r_dv[j-1], 2 * j), 2 * j + 1);
        end
        r_o_vec <= n_o_vec;
        r_o_sb  <= r_dv[DIV_ST-1].sb;
    end

    assign o_valid = r_vld[LAT-1];
    assign o_vec   = r_o_vec;
    assign o_sb    = r_o_sb;

`ifndef SYNTH
    // scaling must put a top bit at TOP unless the vector is zero
    a_scaled_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] && !r_c.zero |->
            (r_c.sm[0][TOP] || r_c.sm[1][TOP] || r_c.sm[2][TOP]))
        else $error("normalizer scaling missed the target range");

    // root of a scaled sum is in [2^30, 2^32)
    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[4+SQ_ST] && !r_sqc[SQ_ST-1].zero |->
            (r_sq[SQ_ST-1].res[63:32] == '0) && (r_sq[SQ_ST-1].res[31:30] != 2'b00))
        else $error("normalizer root out of range");

    // unit vector components never exceed one
    a_unit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |->
            ($signed(o_vec[0]) <= ONE) && ($signed(o_vec[0]) >= -ONE) &&
            ($signed(o_vec[1]) <= ONE) && ($signed(o_vec[1]) >= -ONE) &&
            ($signed(o_vec[2]) <= ONE) && ($signed(o_vec[2]) >= -ONE))
        else $error("normalized component above one");
`endif

endmodule

// ----- rtl/core/lookat_view_matrix.sv -----
// Top level of the look-at view matrix block: world-up registers, cross and
// dot product stages around two normalizer pipelines.
// Depends on lvm_pkg and lvm_norm.
//
// Fully pipelined: a new camera (eye, aim) beat is taken every cycle (busy is
// never raised). Its matrix beat is taken off o_res, with o_valid high, once it
// has passed the input register, both normalizers, the cross product stages
// and the dot product and output stages.
// The depth is set mostly by the two normalizers, each a 64-bit square root at two
// bits per stage followed by dividers at two quotient bits per stage. Results
// are shown for one cycle and the receiver cannot stall them. World-up
// registers are written through the plain write port and must only change
// while no beat is in flight.
module lookat_view_matrix
    import lvm_pkg::*;
#(
    parameter int FRAC_BITS = LVM_FRAC_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_in               i_in,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [31:0]       i_cfg_data,
    output logic              o_valid,
    output t_out              o_res
);

    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

    logic signed [31:0]  r_wup_x;
    logic signed [31:0]  r_wup_y;
    logic signed [31:0]  r_wup_z;

    logic                r_t0_vld;
    logic [2:0][31:0]    r_t0_eye;
    logic [2:0][NW-1:0]  r_t0_dir;

    logic                w_n1_vld;
    logic [2:0][31:0]    w_n1_front;
    logic [2:0][31:0]    w_n1_eye;

    logic                r_p1_vld;
    logic signed [63:0]  r_p1 [6];
    logic [2:0][31:0]    r_p1_front;
    logic [2:0][31:0]    r_p1_eye;

    logic                r_s1_vld;
    logic [2:0][NW-1:0]  r_s1_raw;
    logic [2:0][31:0]    r_s1_front;
    logic [2:0][31:0]    r_s1_eye;

    logic                w_n2_vld;
    logic [2:0][31:0]    w_n2_side;
    logic [5:0][31:0]    w_n2_sb;
    logic [2:0][31:0]    w_n2_front;
    logic [2:0][31:0]    w_n2_eye;

    logic                r_a_vld;
    logic [2:0][31:0]    r_a_side;
    logic [2:0][31:0]    r_a_front;
    logic [2:0][31:0]    r_a_eye;
    logic signed [63:0]  r_a_pu [6];
    logic signed [63:0]  r_a_ps [3];
    logic signed [63:0]  r_a_pf [3];

    logic                r_b_vld;
    logic [2:0][31:0]    r_b_side;
    logic [2:0][31:0]    r_b_front;
    logic [2:0][31:0]    r_b_eye;
    logic signed [63:0]  r_b_up [3];
    logic signed [63:0]  r_b_ds;
    logic signed [63:0]  r_b_df;

    logic                r_c_vld;
    logic [2:0][31:0]    r_c_side;
    logic [2:0][31:0]    r_c_front;
    logic [2:0][31:0]    r_c_eye;
    logic [2:0][31:0]    r_c_up;
    logic signed [31:0]  r_c_m03;
    logic signed [31:0]  r_c_m23;

    logic                r_d_vld;
    logic [2:0][31:0]    r_d_side;
    logic [2:0][31:0]    r_d_front;
    logic [2:0][31:0]    r_d_up;
    logic signed [31:0]  r_d_m03;
    logic signed [31:0]  r_d_m23;
    logic signed [63:0]  r_d_pe [3];

    logic                r_e_vld;
    logic [2:0][31:0]    r_e_side;
    logic [2:0][31:0]    r_e_front;
    logic [2:0][31:0]    r_e_up;
    logic signed [31:0]  r_e_m03;
    logic signed [31:0]  r_e_m23;
    logic signed [63:0]  r_e_dot;

    logic                r_out_vld;
    t_out                r_out;
    t_out                n_out;

    logic                w_accept;

    // Never stalls
    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // World-up registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wup_x <= '0;
            r_wup_y <= ONE;
            r_wup_z <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_UP_X: r_wup_x <= i_cfg_data;
                REG_UP_Y: r_wup_y <= i_cfg_data;
                REG_UP_Z: r_wup_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Valid bits of the local stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t0_vld  <= 1'b0;
            r_p1_vld  <= 1'b0;
            r_s1_vld  <= 1'b0;
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_c_vld   <= 1'b0;
            r_d_vld   <= 1'b0;
            r_e_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_t0_vld  <= w_accept;
            r_p1_vld  <= w_n1_vld;
            r_s1_vld  <= r_p1_vld;
            r_a_vld   <= w_n2_vld;
            r_b_vld   <= r_a_vld;
            r_c_vld   <= r_b_vld;
            r_d_vld   <= r_c_vld;
            r_e_vld   <= r_d_vld;
            r_out_vld <= r_e_vld;
        end
    end

    // Input stage: capture eye and the eye-to-aim direction
    always_ff @(posedge i_clk) begin
        r_t0_eye[0] <= i_in.eye_x;
        r_t0_eye[1] <= i_in.eye_y;
        r_t0_eye[2] <= i_in.eye_z;
        r_t0_dir[0] <= NW'(i_in.aim_x) - NW'(i_in.eye_x);
        r_t0_dir[1] <= NW'(i_in.aim_y) - NW'(i_in.eye_y);
        r_t0_dir[2] <= NW'(i_in.aim_z) - NW'(i_in.eye_z);
    end

    // Front = normalized direction, eye rides along
    lvm_norm #(
        .FRAC_BITS (FRAC_BITS),
        .SB_W      (96)
    ) u_norm_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_t0_vld),
        .i_vec   (r_t0_dir),
        .i_sb    (r_t0_eye),
        .o_valid (w_n1_vld),
        .o_vec   (w_n1_front),
        .o_sb    (w_n1_eye)
    );

    // Front x world-up: products, then truncated differences
    always_ff @(posedge i_clk) begin
        r_p1[0]    <= smul(w_n1_front[1], r_wup_z);
        r_p1[1]    <= smul(w_n1_front[2], r_wup_y);
        r_p1[2]    <= smul(w_n1_front[2], r_wup_x);
        r_p1[3]    <= smul(w_n1_front[0], r_wup_z);
        r_p1[4]    <= smul(w_n1_front[0], r_wup_y);
        r_p1[5]    <= smul(w_n1_front[1], r_wup_x);
        r_p1_front <= w_n1_front;
        r_p1_eye   <= w_n1_eye;

        r_s1_raw[0] <= NW'(qtr(r_p1[0], FRAC_BITS) - qtr(r_p1[1], FRAC_BITS));
        r_s1_raw[1] <= NW'(qtr(r_p1[2], FRAC_BITS) - qtr(r_p1[3], FRAC_BITS));
        r_s1_raw[2] <= NW'(qtr(r_p1[4], FRAC_BITS) - qtr(r_p1[5], FRAC_BITS));
        r_s1_front  <= r_p1_front;
        r_s1_eye    <= r_p1_eye;
    end

    // Side = normalized cross product, front and eye ride along
    lvm_norm #(
        .FRAC_BITS (FRAC_BITS),
        .SB_W      (192)
    ) u_norm_side (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_vld),
        .i_vec   (r_s1_raw),
        .i_sb    ({r_s1_front, r_s1_eye}),
        .o_valid (w_n2_vld),
        .o_vec   (w_n2_side),
        .o_sb    (w_n2_sb)
    );

    assign w_n2_front = w_n2_sb[5:3];
    assign w_n2_eye   = w_n2_sb[2:0];

    // Up = side x front, translation dots: products, sums, saturation
    always_ff @(posedge i_clk) begin
        r_a_pu[0] <= smul(w_n2_side[1], w_n2_front[2]);
        r_a_pu[1] <= smul(w_n2_side[2], w_n2_front[1]);
        r_a_pu[2] <= smul(w_n2_side[2], w_n2_front[0]);
        r_a_pu[3] <= smul(w_n2_side[0], w_n2_front[2]);
        r_a_pu[4] <= smul(w_n2_side[0], w_n2_front[1]);
        r_a_pu[5] <= smul(w_n2_side[1], w_n2_front[0]);
        for (int i = 0; i < 3; i++) begin
            r_a_ps[i] <= smul(w_n2_side[i], w_n2_eye[i]);
            r_a_pf[i] <= smul(w_n2_front[i], w_n2_eye[i]);
        end
        r_a_side  <= w_n2_side;
        r_a_front <= w_n2_front;
        r_a_eye   <= w_n2_eye;

        r_b_up[0] <= qtr(r_a_pu[0], FRAC_BITS) - qtr(r_a_pu[1], FRAC_BITS);
        r_b_up[1] <= qtr(r_a_pu[2], FRAC_BITS) - qtr(r_a_pu[3], FRAC_BITS);
        r_b_up[2] <= qtr(r_a_pu[4], FRAC_BITS) - qtr(r_a_pu[5], FRAC_BITS);
        r_b_ds    <= qtr(r_a_ps[0], FRAC_BITS) + qtr(r_a_ps[1], FRAC_BITS)
                   + qtr(r_a_ps[2], FRAC_BITS);
        r_b_df    <= qtr(r_a_pf[0], FRAC_BITS) + qtr(r_a_pf[1], FRAC_BITS)
                   + qtr(r_a_pf[2], FRAC_BITS);
        r_b_side  <= r_a_side;
        r_b_front <= r_a_front;
        r_b_eye   <= r_a_eye;

        for (int i = 0; i < 3; i++) begin
            r_c_up[i] <= sat32(r_b_up[i]);
        end
        r_c_m03   <= sat32(-r_b_ds);
        r_c_m23   <= sat32(r_b_df);
        r_c_side  <= r_b_side;
        r_c_front <= r_b_front;
        r_c_eye   <= r_b_eye;

        for (int i = 0; i < 3; i++) begin
            r_d_pe[i] <= smul(r_c_up[i], r_c_eye[i]);
        end
        r_d_up    <= r_c_up;
        r_d_m03   <= r_c_m03;
        r_d_m23   <= r_c_m23;
        r_d_side  <= r_c_side;
        r_d_front <= r_c_front;

        r_e_dot   <= qtr(r_d_pe[0], FRAC_BITS) + qtr(r_d_pe[1], FRAC_BITS)
                   + qtr(r_d_pe[2], FRAC_BITS);
        r_e_up    <= r_d_up;
        r_e_m03   <= r_d_m03;
        r_e_m23   <= r_d_m23;
        r_e_side  <= r_d_side;
        r_e_front <= r_d_front;

        r_out <= n_out;
    end

    // Result beat assembly
    always_comb begin
        n_out.m00 = r_e_side[0];
        n_out.m01 = r_e_side[1];
        n_out.m02 = r_e_side[2];
        n_out.m10 = r_e_up[0];
        n_out.m11 = r_e_up[1];
        n_out.m12 = r_e_up[2];
        n_out.m20 = -$signed(r_e_front[0]);
        n_out.m21 = -$signed(r_e_front[1]);
        n_out.m22 = -$signed(r_e_front[2]);
        n_out.m03 = r_e_m03;
        n_out.m13 = sat32(-r_e_dot);
        n_out.m23 = r_e_m23;
    end

    assign o_valid = r_out_vld;
    assign o_res   = r_out;

`ifndef SYNTH
    // world-up leaves reset as the y axis
    a_wup_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> (r_wup_x == '0) && (r_wup_y == ONE) && (r_wup_z == '0))
        else $error("world-up registers not at reset value");

    // busy is tied low, every start is taken
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

    // a result strobe always has a beat in the last local stage behind it
    a_out_from_e: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_e_vld))
        else $error("result strobe without a beat behind it");
`endif

endmodule

// ----- test/tb_top.sv -----
// Testbench for lookat_view_matrix: directed table plus random camera beats,
// each result checked field by field against a fixed-point look-at predictor.
// Depends on lvm_pkg and the lookat_view_matrix RTL.
module tb_top;
    import lvm_pkg::*;

    localparam int FB = LVM_FRAC_BITS;
    localparam int LATENCY = 9 + 2 * (22 + (FB + 2) / 2);
    localparam int SETTLE = LATENCY + 10;
    localparam logic [CFG_IW-1:0] REG_SPARE = 2'd3;
    localparam int ONE = 1 << FB;

    typedef longint vec3_t[3];

    typedef struct {
        t_in  beat;
        bit   typed;
        t_out want;
    } row_t;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    t_in               i_in;
    logic              i_cfg_we;
    logic [CFG_IW-1:0] i_cfg_idx;
    logic [31:0]       i_cfg_data;
    logic              o_valid;
    t_out              o_res;

    // Model copy of the world-up registers
    longint up_reg[3];
    t_out   matrix_q[$];
    int     n_err;
    bit     done;

    lookat_view_matrix DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_in(i_in),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .o_res(o_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Fixed-point product, truncated toward zero
    function automatic longint fx_mul(longint a, longint b);
        longint p;
        p = a * b;
        if (p < 0) begin
            return -((-p) >>> FB);
        end
        return p >>> FB;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Unit vector; zero length gives (1,0,0)
    function automatic vec3_t unit_vec(vec3_t v);
        longint unsigned mag[3];
        bit neg[3];
        longint unsigned m, sum, len, q;
        vec3_t r;
        m = 0;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = v[i] < 0;
            mag[i] = neg[i] ? -v[i] : v[i];
            if (mag[i] > m) m = mag[i];
        end
        if (m == 0) begin
            r[0] = ONE;
            r[1] = 0;
            r[2] = 0;
            return r;
        end
        while (m >= (64'd1 << 31)) begin
            m >>= 1;
            for (int i = 0; i < 3; i++) mag[i] >>= 1;
        end
        while (m < (64'd1 << 30)) begin
            m <<= 1;
            for (int i = 0; i < 3; i++) mag[i] <<= 1;
        end
        for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q = (mag[i] << FB) / len;
            r[i] = neg[i] ? -longint'(q) : longint'(q);
        end
        return r;
    endfunction

    function automatic vec3_t cross3(vec3_t a, vec3_t b);
        vec3_t r;
        r[0] = fx_mul(a[1], b[2]) - fx_mul(a[2], b[1]);
        r[1] = fx_mul(a[2], b[0]) - fx_mul(a[0], b[2]);
        r[2] = fx_mul(a[0], b[1]) - fx_mul(a[1], b[0]);
        return r;
    endfunction

    function automatic longint dot3(vec3_t a, vec3_t b);
        return fx_mul(a[0], b[0]) + fx_mul(a[1], b[1]) + fx_mul(a[2], b[2]);
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Expected view matrix for one camera beat under the current world up
    function automatic t_out view_matrix(t_in b);
        vec3_t eye, dir, front, side, up, wup;
        t_out o;
        eye = '{longint'(b.eye_x), longint'(b.eye_y), longint'(b.eye_z)};
        dir = '{longint'(b.aim_x) - eye[0], longint'(b.aim_y) - eye[1],
                longint'(b.aim_z) - eye[2]};
        wup = up_reg;
        front = unit_vec(dir);
        side = unit_vec(cross3(front, wup));
        up = cross3(side, front);
        for (int i = 0; i < 3; i++) up[i] = clamp32(up[i]);
        o.m00 = 32'(side[0]);   o.m01 = 32'(side[1]);   o.m02 = 32'(side[2]);
        o.m10 = 32'(up[0]);     o.m11 = 32'(up[1]);     o.m12 = 32'(up[2]);
        o.m20 = 32'(-front[0]); o.m21 = 32'(-front[1]); o.m22 = 32'(-front[2]);
        o.m03 = 32'(clamp32(-dot3(side, eye)));
        o.m13 = 32'(clamp32(-dot3(up, eye)));
        o.m23 = 32'(clamp32(dot3(front, eye)));
        return o;
    endfunction

    task automatic report(string what, int fld, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s field %0d: got %h want %h at %0t", what, fld, got, want, $time);
        n_err++;
    endtask

    // Result checker: one beat per strobe, compared with the oldest expectation
    always @(posedge i_clk) begin
        t_out w;
        if (i_rst_n && o_valid) begin
            if (matrix_q.size() == 0) begin
                report("unexpected beat", 0, o_res.m00, 32'h0);
            end else begin
                w = matrix_q.pop_front();
                for (int i = 0; i < 12; i++) begin
                    if (o_res[383 - 32 * i -: 32] !== w[383 - 32 * i -: 32]) begin
                        report("result", i, o_res[383 - 32 * i -: 32], w[383 - 32 * i -: 32]);
                    end
                end
            end
        end
    end

    task automatic cfg_write(logic [CFG_IW-1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        if (idx != REG_SPARE) up_reg[idx] = longint'(signed'(val));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        wait (matrix_q.size() == 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // Present one beat after an idle gap; called at a falling edge
    task automatic send(t_in b, int gap, bit typed, t_out want);
        repeat (gap) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_in <= b;
        do @(posedge i_clk); while (busy);
        matrix_q.push_back(typed ? want : view_matrix(b));
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rnd_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 2 * ONE * 64))) - ONE * 64;
            2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 2048))) - 1024;
        endcase
    endfunction

    function automatic t_in rnd_beat();
        t_in b;
        int mode, kind;
        mode = $urandom_range(0, 3);
        kind = $urandom_range(0, 9);
        b.eye_x = rnd_coord(mode); b.eye_y = rnd_coord(mode); b.eye_z = rnd_coord(mode);
        b.aim_x = rnd_coord(mode); b.aim_y = rnd_coord(mode); b.aim_z = rnd_coord(mode);
        if (kind == 0) begin
            // camera on its own target
            b.aim_x = b.eye_x; b.aim_y = b.eye_y; b.aim_z = b.eye_z;
        end else if (kind == 1) begin
            // looking along world up
            b.aim_x = b.eye_x + 32'(up_reg[0] >>> 4);
            b.aim_y = b.eye_y + 32'(up_reg[1] >>> 4);
            b.aim_z = b.eye_z + 32'(up_reg[2] >>> 4);
        end
        return b;
    endfunction

    task automatic random_phase(int n);
        int gap, quiet;
        t_out none;
        none = '0;
        quiet = 0;
        for (int k = 0; k < n; k++) begin
            if (k % 40 == 0) quiet = $urandom_range(0, 2) == 0;
            gap = quiet ? 0 : $urandom_range(0, 18);
            if (k == n / 2) begin
                // let the pipeline run dry once mid-phase
                start <= 1'b0;
                wait (matrix_q.size() == 0);
                @(negedge i_clk);
            end
            send(rnd_beat(), gap, 1'b0, none);
        end
        start <= 1'b0;
    endtask

    initial begin
        row_t table_rows[$];
        row_t r;
        t_out id_mat, still;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_in = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        n_err = 0;
        done = 0;
        up_reg = '{0, ONE, 0};
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Identity view: camera at origin looking down -z
        id_mat = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, 0};
        // Camera on its target: front falls back to +x
        still = '{0, 0, ONE, 0, ONE, 0, -ONE, 0, 0, 0, 0, 0};
        r.typed = 1; r.beat = '{0, 0, 0, 0, 0, -ONE}; r.want = id_mat;
        table_rows.push_back(r);
        r.beat = '{0, 0, 0, 0, 0, 0}; r.want = still;
        table_rows.push_back(r);
        r.typed = 0; r.want = '0;
        r.beat = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                   32'h80000000};
        table_rows.push_back(r);
        r.beat = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                   32'h7fffffff};
        table_rows.push_back(r);
        r.beat = '{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                   32'h7fffffff};
        table_rows.push_back(r);
        r.beat = '{0, 0, 0, 0, ONE, 0};          // along up: no side
        table_rows.push_back(r);
        r.beat = '{0, 0, 0, 0, -ONE * 100, 0};   // against up
        table_rows.push_back(r);
        r.beat = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0};  // translation clamp
        table_rows.push_back(r);
        r.beat = '{32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0};
        table_rows.push_back(r);
        r.beat = '{1, 2, 3, 1, 2, 4};
        table_rows.push_back(r);
        r.beat = '{32'hffffffff, 0, 32'hffffffff, 0, 32'hffffffff, 0};
        table_rows.push_back(r);
        r.beat = '{ONE * 3, -ONE * 5, ONE * 7, -ONE * 2, ONE * 9, ONE};
        table_rows.push_back(r);
        foreach (table_rows[i]) begin
            send(table_rows[i].beat, i % 3, table_rows[i].typed, table_rows[i].want);
        end
        random_phase(300);
        drain();

        // Zero world up: side always falls back, spare index ignored
        cfg_write(REG_UP_X, 32'h0);
        cfg_write(REG_UP_Y, 32'h0);
        cfg_write(REG_UP_Z, 32'h0);
        cfg_write(REG_SPARE, 32'hdeadbeef);
        table_rows[0].typed = 0;
        table_rows[1].typed = 0;
        foreach (table_rows[i]) begin
            send(table_rows[i].beat, 0, 1'b0, table_rows[i].want);
        end
        random_phase(200);
        drain();

        // Extreme world up
        cfg_write(REG_UP_X, 32'h7fffffff);
        cfg_write(REG_UP_Y, 32'h80000000);
        cfg_write(REG_UP_Z, 32'h7fffffff);
        foreach (table_rows[i]) begin
            send(table_rows[i].beat, 1, 1'b0, table_rows[i].want);
        end
        random_phase(250);
        drain();

        cfg_write(REG_UP_X, 32'h80000000);
        cfg_write(REG_UP_Y, 32'h80000000);
        cfg_write(REG_UP_Z, 32'h80000000);
        random_phase(200);
        drain();

        // Z-up and a few random settings
        cfg_write(REG_UP_X, 32'h0);
        cfg_write(REG_UP_Y, 32'h0);
        cfg_write(REG_UP_Z, ONE);
        random_phase(150);
        for (int p = 0; p < 3; p++) begin
            drain();
            cfg_write(REG_UP_X, $urandom());
            cfg_write(REG_UP_Y, $urandom());
            cfg_write(REG_UP_Z, $urandom());
            random_phase(100);
        end

        wait (matrix_q.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
        done = 1;
        if (n_err == 0 && matrix_q.size() == 0) begin
            $display("PASS lookat_view_matrix");
        end else begin
            $display("FAIL lookat_view_matrix");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #4000000;
        if (!done) begin
            $display("FAIL lookat_view_matrix");
            $finish;
        end
    end

endmodule
